[rtl/tlbcp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// TLB clock translate package
// Shared constants and types for the TLB page translation block.
// ----------------------------------------------------------------------------
package tlbcp_pkg;
	localparam int TLB_ENTRIES_DEF  = 16;
	localparam int PAGE_COUNT_DEF   = 1024;
	localparam int OFFSET_WIDTH_DEF = 10;
	localparam int VA_WIDTH         = 20;
	localparam int FP_WIDTH         = 10;
	localparam int CNT_WIDTH        = 32;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_TABLE,
		ST_SWEEP,
		ST_OUT
	} back_state_t;
endpackage
`default_nettype wire

[rtl/tlb_clock_page_translate.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// TLB clock page translate
// Translates one address per item through a TLB with clock replacement.
// ----------------------------------------------------------------------------
// A front queue of two items takes addresses while the back end works. A TLB
// hit passes the idle, lookup and output states; a miss also passes the table
// state and stays in sweep while the clock hand clears set reference bits. The
// page table is a single-port memory read in the cycle before its update, with
// the valid bit stored beside the frame. After reset the back end clears all
// PAGE_COUNT table entries (1024 by default) before it takes the first item.
module tlb_clock_page_translate #(
	parameter int TLB_ENTRIES = tlbcp_pkg::TLB_ENTRIES_DEF,
	parameter int PAGE_COUNT = tlbcp_pkg::PAGE_COUNT_DEF,
	parameter int OFFSET_WIDTH = tlbcp_pkg::OFFSET_WIDTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [tlbcp_pkg::VA_WIDTH-1:0]       virtual_address,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [tlbcp_pkg::VA_WIDTH-1:0]            phys_addr,
	output logic                                      tlb_hit,
	output logic                                      page_fault,
	output logic [tlbcp_pkg::FP_WIDTH-1:0]            fault_page,
	output logic [tlbcp_pkg::CNT_WIDTH-1:0]           addresses_so_far,
	output logic [tlbcp_pkg::CNT_WIDTH-1:0]           hits_so_far,
	output logic [tlbcp_pkg::CNT_WIDTH-1:0]           faults_so_far
);
	localparam int PAGE_W = $clog2(PAGE_COUNT);
	localparam int IDX_W = $clog2(TLB_ENTRIES);

	logic q_valid, q_take;
	logic [PAGE_W-1:0] q_page;
	logic [OFFSET_WIDTH-1:0] q_offset;

	tlbcp_front #(.PAGE_W(PAGE_W), .OFFSET_WIDTH(OFFSET_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .stall(in_stall),
		.virtual_address(virtual_address), .q_valid(q_valid), .q_take(q_take),
		.q_page(q_page), .q_offset(q_offset)
	);

	tlbcp_back #(
		.TLB_ENTRIES(TLB_ENTRIES), .PAGE_COUNT(PAGE_COUNT),
		.OFFSET_WIDTH(OFFSET_WIDTH), .PAGE_W(PAGE_W), .IDX_W(IDX_W)
	) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_take(q_take),
		.q_page(q_page), .q_offset(q_offset), .out_valid(out_valid),
		.out_stall(out_stall), .phys_addr(phys_addr),
		.tlb_hit(tlb_hit), .page_fault(page_fault), .fault_page(fault_page),
		.addresses_so_far(addresses_so_far), .hits_so_far(hits_so_far),
		.faults_so_far(faults_so_far)
	);
endmodule
`default_nettype wire

[rtl/tlbcp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// TLB clock translate front end
// Accepts addresses and splits them into page and offset in a two-entry queue.
// ----------------------------------------------------------------------------
module tlbcp_front #(
	parameter int PAGE_W = 10,
	parameter int OFFSET_WIDTH = 10
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 valid,
	output logic                                      stall,
	input  wire logic [tlbcp_pkg::VA_WIDTH-1:0]       virtual_address,
	output logic                                      q_valid,
	input  wire logic                                 q_take,
	output logic [PAGE_W-1:0]                         q_page,
	output logic [OFFSET_WIDTH-1:0]                   q_offset
);
	logic [PAGE_W-1:0] page_q [2];
	logic [OFFSET_WIDTH-1:0] off_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push, pop;
	logic [tlbcp_pkg::VA_WIDTH-1:0] hi;

	assign stall = (cnt_q == 2'd2);
	assign push = valid && !stall;
	assign pop = q_take && q_valid;
	assign q_valid = (cnt_q != 2'd0);
	assign q_page = page_q[rd_q];
	assign q_offset = off_q[rd_q];
	assign hi = virtual_address >> OFFSET_WIDTH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			page_q[wr_q] <= hi[PAGE_W-1:0];
			off_q[wr_q] <= virtual_address[OFFSET_WIDTH-1:0];
		end
	end
endmodule
`default_nettype wire

[rtl/tlbcp_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// TLB clock translate back end
// TLB lookup, page table access, clock replacement and result register.
// ----------------------------------------------------------------------------
module tlbcp_back #(
	parameter int TLB_ENTRIES = 16,
	parameter int PAGE_COUNT = 1024,
	parameter int OFFSET_WIDTH = 10,
	parameter int PAGE_W = 10,
	parameter int IDX_W = 4
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 q_valid,
	output logic                                      q_take,
	input  wire logic [PAGE_W-1:0]                    q_page,
	input  wire logic [OFFSET_WIDTH-1:0]              q_offset,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [tlbcp_pkg::VA_WIDTH-1:0]            phys_addr,
	output logic                                      tlb_hit,
	output logic                                      page_fault,
	output logic [tlbcp_pkg::FP_WIDTH-1:0]            fault_page,
	output logic [tlbcp_pkg::CNT_WIDTH-1:0]           addresses_so_far,
	output logic [tlbcp_pkg::CNT_WIDTH-1:0]           hits_so_far,
	output logic [tlbcp_pkg::CNT_WIDTH-1:0]           faults_so_far
);
	localparam int CW = tlbcp_pkg::CNT_WIDTH;
	localparam int VW = tlbcp_pkg::VA_WIDTH;

	tlbcp_pkg::back_state_t state_q, state_d;

	logic [PAGE_W-1:0] tag_q [TLB_ENTRIES];
	logic [PAGE_W-1:0] frm_q [TLB_ENTRIES];
	logic [TLB_ENTRIES-1:0] vld_q, ref_q;
	logic [IDX_W-1:0] hand_q;
	logic [PAGE_W:0] tmem [PAGE_COUNT];
	logic [PAGE_W:0] tmem_rd_q;
	logic [PAGE_W-1:0] clr_q;
	logic [PAGE_W-1:0] next_frame_q;
	logic [CW-1:0] addr_tot_q, hit_tot_q, fault_tot_q;

	logic [PAGE_W-1:0] page_q, frame_q;
	logic [OFFSET_WIDTH-1:0] off_q;
	logic hit_q, fault_q;

	logic [TLB_ENTRIES-1:0] match;
	logic [PAGE_W-1:0] hit_frame;
	logic hit_any;
	logic [VW+PAGE_W-1:0] pa_wide;

	always_comb begin
		hit_frame = '0;
		for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
			match[i] = vld_q[i] && (tag_q[i] == page_q);
			if (match[i]) hit_frame = frm_q[i];
		end
		hit_any = |match;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tlbcp_pkg::ST_CLEAR: if (clr_q == PAGE_W'(PAGE_COUNT - 1)) state_d = tlbcp_pkg::ST_IDLE;
			tlbcp_pkg::ST_IDLE: if (q_valid) state_d = tlbcp_pkg::ST_LOOKUP;
			tlbcp_pkg::ST_LOOKUP: state_d = hit_any ? tlbcp_pkg::ST_OUT : tlbcp_pkg::ST_TABLE;
			tlbcp_pkg::ST_TABLE: state_d = tlbcp_pkg::ST_SWEEP;
			tlbcp_pkg::ST_SWEEP: if (!ref_q[hand_q]) state_d = tlbcp_pkg::ST_OUT;
			tlbcp_pkg::ST_OUT: if (!out_stall) state_d = tlbcp_pkg::ST_IDLE;
			default: state_d = tlbcp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		q_take = (state_q == tlbcp_pkg::ST_IDLE);
		out_valid = (state_q == tlbcp_pkg::ST_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlbcp_pkg::ST_CLEAR;
			clr_q <= '0;
			vld_q <= '0;
			ref_q <= '0;
			hand_q <= '0;
			next_frame_q <= '0;
			addr_tot_q <= '0;
			hit_tot_q <= '0;
			fault_tot_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				tlbcp_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				tlbcp_pkg::ST_IDLE: begin
				end
				tlbcp_pkg::ST_LOOKUP: begin
					addr_tot_q <= addr_tot_q + 1'b1;
					if (hit_any) begin
						hit_tot_q <= hit_tot_q + 1'b1;
						ref_q <= ref_q | match;
					end
				end
				tlbcp_pkg::ST_TABLE: begin
					if (!tmem_rd_q[PAGE_W]) begin
						fault_tot_q <= fault_tot_q + 1'b1;
						if (next_frame_q == PAGE_W'(PAGE_COUNT - 1))
							next_frame_q <= '0;
						else
							next_frame_q <= next_frame_q + 1'b1;
					end
				end
				tlbcp_pkg::ST_SWEEP: begin
					if (ref_q[hand_q]) begin
						ref_q[hand_q] <= 1'b0;
					end else begin
						vld_q[hand_q] <= 1'b1;
						ref_q[hand_q] <= 1'b1;
					end
					if (hand_q == IDX_W'(TLB_ENTRIES - 1)) hand_q <= '0;
					else hand_q <= hand_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tlbcp_pkg::ST_CLEAR: begin
				tmem[clr_q] <= '0;
			end
			tlbcp_pkg::ST_IDLE: begin
				page_q <= q_page;
				off_q <= q_offset;
			end
			tlbcp_pkg::ST_LOOKUP: begin
				hit_q <= hit_any;
				fault_q <= 1'b0;
				frame_q <= hit_frame;
				tmem_rd_q <= tmem[page_q];
			end
			tlbcp_pkg::ST_TABLE: begin
				if (tmem_rd_q[PAGE_W]) begin
					frame_q <= tmem_rd_q[PAGE_W-1:0];
				end else begin
					frame_q <= next_frame_q;
					fault_q <= 1'b1;
					tmem[page_q] <= {1'b1, next_frame_q};
				end
			end
			tlbcp_pkg::ST_SWEEP: begin
				if (!ref_q[hand_q]) begin
					tag_q[hand_q] <= page_q;
					frm_q[hand_q] <= frame_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign pa_wide = ((VW+PAGE_W)'(frame_q) << OFFSET_WIDTH) | (VW+PAGE_W)'(off_q);
	assign phys_addr = pa_wide[VW-1:0];
	assign tlb_hit = hit_q;
	assign page_fault = fault_q;
	assign fault_page = fault_q ? tlbcp_pkg::FP_WIDTH'(page_q) : '0;
	assign addresses_so_far = addr_tot_q;
	assign hits_so_far = hit_tot_q;
	assign faults_so_far = fault_tot_q;
endmodule
`default_nettype wire

[tb/tlb_clock_page_translate_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLB clock page translate checker
// Watches both channels of the translation block and keeps its own copy of
// the TLB, the clock hand, the page table and the counters. Every accepted
// address produces one expected translation, and every accepted result is
// compared field by field against the oldest one still waiting.
// ----------------------------------------------------------------------------
module tlb_clock_page_translate_check (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [19:0] virtual_address,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [19:0] phys_addr,
	input  wire logic        tlb_hit,
	input  wire logic        page_fault,
	input  wire logic [9:0]  fault_page,
	input  wire logic [31:0] addresses_so_far,
	input  wire logic [31:0] hits_so_far,
	input  wire logic [31:0] faults_so_far,
	output int               errors,
	output int               pending
);
	typedef struct packed {
		logic [19:0] pa;
		logic        hit;
		logic        fault;
		logic [9:0]  fpage;
		logic [31:0] n_addr;
		logic [31:0] n_hit;
		logic [31:0] n_fault;
	} xlate_t;

	logic [9:0]  tag [16];
	logic [9:0]  tframe [16];
	logic        tvalid [16];
	logic        tref [16];
	logic [3:0]  hand;
	logic [9:0]  pt_frame [1024];
	logic        pt_valid [1024];
	logic [9:0]  frame_ctr;
	logic [31:0] cnt_addr, cnt_hit, cnt_fault;
	xlate_t      translations [$];

	assign pending = translations.size();

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("error at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic xlate_t translate(input logic [19:0] va);
		xlate_t r;
		logic [9:0] page, frame;
		logic [3:0] h;
		r = '0;
		page = va[19:10];
		frame = '0;
		cnt_addr++;
		for (int i = 0; i < 16; i++)
			if (tvalid[i] && tag[i] == page && !r.hit) begin
				frame = tframe[i];
				r.hit = 1'b1;
			end
		if (r.hit) begin
			cnt_hit++;
		end else begin
			if (pt_valid[page]) begin
				frame = pt_frame[page];
			end else begin
				r.fault = 1'b1;
				r.fpage = page;
				cnt_fault++;
				frame = frame_ctr;
				pt_frame[page] = frame;
				pt_valid[page] = 1'b1;
				frame_ctr++;
			end
			h = hand;
			while (tref[h]) begin
				tref[h] = 1'b0;
				h++;
			end
			tag[h] = page;
			tframe[h] = frame;
			tvalid[h] = 1'b1;
			tref[h] = 1'b1;
			hand = h + 4'd1;
		end
		for (int i = 0; i < 16; i++)
			if (tvalid[i] && tag[i] == page)
				tref[i] = 1'b1;
		r.pa = {frame, va[9:0]};
		r.n_addr = cnt_addr;
		r.n_hit = cnt_hit;
		r.n_fault = cnt_fault;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		xlate_t e;
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				tag[i] = '0;
				tframe[i] = '0;
				tvalid[i] = 1'b0;
				tref[i] = 1'b0;
			end
			for (int i = 0; i < 1024; i++) begin
				pt_frame[i] = '0;
				pt_valid[i] = 1'b0;
			end
			hand = '0;
			frame_ctr = '0;
			cnt_addr = '0;
			cnt_hit = '0;
			cnt_fault = '0;
			translations.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (translations.size() == 0) begin
					report("result with nothing expected", 32'(phys_addr), '0);
				end else begin
					e = translations.pop_front();
					if (phys_addr !== e.pa)
						report("phys_addr", 32'(phys_addr), 32'(e.pa));
					if (tlb_hit !== e.hit)
						report("tlb_hit", 32'(tlb_hit), 32'(e.hit));
					if (page_fault !== e.fault)
						report("page_fault", 32'(page_fault), 32'(e.fault));
					if (fault_page !== e.fpage)
						report("fault_page", 32'(fault_page), 32'(e.fpage));
					if (addresses_so_far !== e.n_addr)
						report("addresses_so_far", addresses_so_far, e.n_addr);
					if (hits_so_far !== e.n_hit)
						report("hits_so_far", hits_so_far, e.n_hit);
					if (faults_so_far !== e.n_fault)
						report("faults_so_far", faults_so_far, e.n_fault);
				end
			end
			if (in_valid && !in_stall)
				translations.push_back(translate(virtual_address));
		end
	end
endmodule

[tb/tlb_clock_page_translate_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLB clock page translate testbench
// Drives addresses into the translation block with random gaps and result
// stalls. A directed start covers the address extremes, hits, table refills
// and long clock sweeps; the random part mostly revisits a small working
// set so that hits, evictions and refills from the page table all occur.
// ----------------------------------------------------------------------------
module tlb_clock_page_translate_test;
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [19:0] virtual_address;
	logic        out_valid;
	logic        out_stall;
	logic [19:0] phys_addr;
	logic        tlb_hit;
	logic        page_fault;
	logic [9:0]  fault_page;
	logic [31:0] addresses_so_far;
	logic [31:0] hits_so_far;
	logic [31:0] faults_so_far;
	int          errors;
	int          pending;
	bit          calm;
	logic [9:0]  hot_pages [24];

	tlb_clock_page_translate DUT (.*);
	tlb_clock_page_translate_check checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tlb_clock_page_translate: mismatch");
		$finish;
	end

	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send(input logic [19:0] va);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		virtual_address <= va;
		do @(posedge clk); while (in_stall);
	endtask

	initial begin
		in_valid = 1'b0;
		virtual_address = '0;
		calm = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send(20'h00000);
		send(20'hFFFFF);
		send(20'h003FF);
		send(20'hFFC00);
		send(20'h55555);
		send(20'hAAAAA);
		for (int i = 0; i < 18; i++)
			send({10'(i * 37 + 3), 10'($urandom)});
		send(20'h00123);
		for (int i = 0; i < 24; i++)
			hot_pages[i] = 10'($urandom);
		for (int n = 0; n < 550; n++) begin
			if (n > 480)
				calm = 1'b1;
			if ($urandom_range(0, 9) < 8)
				send({hot_pages[$urandom_range(0, 23)], 10'($urandom)});
			else
				send(20'($urandom));
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tlb_clock_page_translate: match");
		else
			$display("tlb_clock_page_translate: mismatch");
		$finish;
	end
endmodule
